### design/sijs_pkg.sv
// Shared types and constants for the sequence-indexed jitter store.
// No dependencies; imported by the channel interfaces and the jitter store unit.
package sijs_pkg;

   localparam int SEQ_BITS             = 16;
   localparam int PAYLOAD_FIELD_BITS   = 32;
   localparam int DEF_SLOT_COUNT       = 64;
   localparam int DEF_PAYLOAD_BITS     = 32;

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_GET  = 1'b1
   } kind_type;

endpackage

### design/sijs_if.sv
// Request and response channel interfaces for the jitter store.
// Depends on sijs_pkg.
interface sijs_req_if;
   import sijs_pkg::*;

   logic                          valid;
   logic                          ready;
   kind_type                      kind;
   logic [SEQ_BITS-1:0]           seq;
   logic [PAYLOAD_FIELD_BITS-1:0] payload_in;
   logic                          consume;

   modport source (output valid, kind, seq, payload_in, consume, input ready);
   modport sink   (input valid, kind, seq, payload_in, consume, output ready);
endinterface

interface sijs_rsp_if;
   import sijs_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [PAYLOAD_FIELD_BITS-1:0] payload_out;

   modport source (output valid, hit, payload_out, input ready);
   modport sink   (input valid, hit, payload_out, output ready);
endinterface

### design/sijs_store.sv
// Slot memory: one write port, one read port with registered read data.
// No package dependencies.
module sijs_store #(
   parameter int DEPTH     = 64,
   parameter int WIDTH     = 49,
   parameter int ADDR_BITS = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/seq_indexed_jitter_store_unit.sv
// Direct-mapped packet store keyed by 16-bit sequence number; slot = seq mod SLOT_COUNT.
// A push writes tag and payload and marks the slot valid; a get returns hit and payload,
// clearing the slot on a consuming hit. One word is accepted per cycle through a
// three-stage pipeline (slot quotient, memory read, compare/write); a get's result passes
// through the stage-1, stage-2 and result registers, and a result held by rsp_if.ready
// stalls the whole pipeline. The slot memory has one read and one write port and is read
// once and written at most once per word, with a bypass for back-to-back words on the
// same slot. After reset a clearing pass writes zero to every slot of the memory, during
// which req_if.ready stays low.
// Depends on sijs_pkg, sijs_if and sijs_store.
module seq_indexed_jitter_store_unit #(
   parameter int SLOT_COUNT   = sijs_pkg::DEF_SLOT_COUNT,
   parameter int PAYLOAD_BITS = sijs_pkg::DEF_PAYLOAD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   sijs_req_if.sink   req_if,
   sijs_rsp_if.source rsp_if
);
   import sijs_pkg::*;

   localparam int SlotBits   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int RecipShift = SEQ_BITS + $clog2(SLOT_COUNT);
   localparam int RecipBits  = SEQ_BITS + 2;
   localparam int ProdBits   = SEQ_BITS + RecipBits;
   localparam longint unsigned RecipFull =
      ((64'd1 << RecipShift) + longint'(SLOT_COUNT) - 1) / longint'(SLOT_COUNT);
   localparam logic [RecipBits-1:0] Recip        = RecipBits'(RecipFull);
   localparam logic [SlotBits-1:0]  SlotCountLow = SlotBits'(SLOT_COUNT);
   localparam logic [SlotBits-1:0]  LastSlot     = SlotBits'(SLOT_COUNT - 1);
   localparam int ExtBits  = (PAYLOAD_BITS > PAYLOAD_FIELD_BITS) ? PAYLOAD_BITS
                                                                 : PAYLOAD_FIELD_BITS;
   localparam int WordBits = 1 + SEQ_BITS + PAYLOAD_BITS;

   // clearing pass
   logic                clear_ff;
   logic [SlotBits-1:0] clr_idx_ff;

   // stage 1
   logic                          v1_ff;
   kind_type                      kind1_ff;
   logic [SEQ_BITS-1:0]           seq1_ff;
   logic [PAYLOAD_FIELD_BITS-1:0] pl1_ff;
   logic                          cons1_ff;
   logic [SEQ_BITS-1:0]           quot1_ff;

   // stage 2
   logic                          v2_ff;
   kind_type                      kind2_ff;
   logic [SEQ_BITS-1:0]           seq2_ff;
   logic [PAYLOAD_FIELD_BITS-1:0] pl2_ff;
   logic                          cons2_ff;
   logic [SlotBits-1:0]           slot2_ff;
   logic                          fwd_hit_ff;
   logic [WordBits-1:0]           fwd_word_ff;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic [PAYLOAD_FIELD_BITS-1:0] rsp_payload_ff;

   logic                          adv;
   logic [ProdBits-1:0]           prod;
   logic [SEQ_BITS-1:0]           quot1_in;
   logic [SlotBits-1:0]           slot1;
   logic [WordBits-1:0]           rd_word;
   logic [WordBits-1:0]           eff_word;
   logic                          eff_valid;
   logic [SEQ_BITS-1:0]           eff_tag;
   logic [PAYLOAD_BITS-1:0]       eff_pl;
   logic [ExtBits-1:0]            eff_pl_ext;
   logic [ExtBits-1:0]            pl2_ext;
   logic                          eff_hit;
   logic                          pipe_wr;
   logic                          mem_wr;
   logic [SlotBits-1:0]           mem_waddr;
   logic [WordBits-1:0]           mem_wdata;
   logic [WordBits-1:0]           pipe_wdata;
   logic                          fwd_hit_in;
   logic                          rsp_valid_in;
   logic                          rsp_hit_in;
   logic [PAYLOAD_FIELD_BITS-1:0] rsp_payload_in;

   assign adv          = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = adv && !clear_ff;

   // quotient by reciprocal, exact for all 16-bit sequence numbers
   assign prod     = ProdBits'(req_if.seq) * ProdBits'(Recip);
   assign quot1_in = SEQ_BITS'(prod >> RecipShift);
   assign slot1    = seq1_ff[SlotBits-1:0]
                   - SlotBits'(quot1_ff[SlotBits-1:0] * SlotCountLow);

   assign eff_word   = fwd_hit_ff ? fwd_word_ff : rd_word;
   assign eff_valid  = eff_word[WordBits-1];
   assign eff_tag    = eff_word[WordBits-2 -: SEQ_BITS];
   assign eff_pl     = eff_word[PAYLOAD_BITS-1:0];
   assign eff_pl_ext = ExtBits'(eff_pl);
   assign pl2_ext    = ExtBits'(pl2_ff);
   assign eff_hit    = eff_valid && (eff_tag == seq2_ff);

   always_comb begin
      pipe_wr    = 1'b0;
      pipe_wdata = {1'b0, eff_tag, eff_pl};
      if (v2_ff && adv) begin
         case (kind2_ff)
            KIND_PUSH: begin
               pipe_wr    = 1'b1;
               pipe_wdata = {1'b1, seq2_ff, pl2_ext[PAYLOAD_BITS-1:0]};
            end
            KIND_GET: begin
               pipe_wr = eff_hit && cons2_ff;
            end
            default: pipe_wr = 1'b0;
         endcase
      end
   end

   assign mem_wr     = clear_ff || pipe_wr;
   assign mem_waddr  = clear_ff ? clr_idx_ff : slot2_ff;
   assign mem_wdata  = clear_ff ? '0 : pipe_wdata;
   assign fwd_hit_in = pipe_wr && v1_ff && (slot2_ff == slot1);

   assign rsp_valid_in   = v2_ff && (kind2_ff == KIND_GET);
   assign rsp_hit_in     = eff_hit;
   assign rsp_payload_in = eff_hit ? eff_pl_ext[PAYLOAD_FIELD_BITS-1:0] : '0;

   sijs_store #(
      .DEPTH     (SLOT_COUNT),
      .WIDTH     (WordBits),
      .ADDR_BITS (SlotBits)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (adv),
      .rd_addr (slot1),
      .rd_data (rd_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clear_ff) begin
         clr_idx_ff <= clr_idx_ff + SlotBits'(1);
         if (clr_idx_ff == LastSlot) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_if.valid && req_if.ready;
         v2_ff        <= v1_ff;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind1_ff       <= req_if.kind;
         seq1_ff        <= req_if.seq;
         pl1_ff         <= req_if.payload_in;
         cons1_ff       <= req_if.consume;
         quot1_ff       <= quot1_in;
         kind2_ff       <= kind1_ff;
         seq2_ff        <= seq1_ff;
         pl2_ff         <= pl1_ff;
         cons2_ff       <= cons1_ff;
         slot2_ff       <= slot1;
         fwd_word_ff    <= pipe_wdata;
         rsp_hit_ff     <= rsp_hit_in;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.hit         = rsp_hit_ff;
   assign rsp_if.payload_out = rsp_payload_ff;

   // no words in flight while the memory is being cleared
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (!req_if.ready && !v1_ff && !v2_ff))
      else $error("word in flight during clearing pass");

   // a miss never carries a payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_payload_ff == '0))
      else $error("miss with nonzero payload");

   // push followed directly by a get of the same number must hit (bypass path)
   a_push_then_get: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && adv && (kind2_ff == KIND_PUSH)) |=>
      ((v2_ff && (kind2_ff == KIND_GET) && (seq2_ff == $past(seq2_ff))) ? eff_hit : 1'b1))
      else $error("get right after push of same sequence missed");

   // a consuming hit followed directly by a get of the same number must miss
   a_consume_then_get: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && adv && (kind2_ff == KIND_GET) && eff_hit && cons2_ff) |=>
      ((v2_ff && (kind2_ff == KIND_GET) && (seq2_ff == $past(seq2_ff))) ? !eff_hit : 1'b1))
      else $error("get right after consuming hit still hit");

endmodule
